/* rtl/idw_four_point_interpolator_defines.svh */
// ----------------------------------------------------------------------------
// IDW interpolator assertion macros
// Shared concurrent assertion wrappers clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef IDW_FOUR_POINT_INTERPOLATOR_DEFINES_SVH
`define IDW_FOUR_POINT_INTERPOLATOR_DEFINES_SVH

// Check a complete property on every clock edge out of reset.
`define IDW_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define IDW_ASSERT_NEXT(label, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

/* rtl/idw4_pkg.sv */
// ----------------------------------------------------------------------------
// IDW interpolator package
// Word types, register indexes and datapath widths of the interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package idw4_pkg;

	localparam int N      = 4;       // neighbours per grid point
	localparam int NB     = 2;       // bits to count N lanes in a sum
	localparam int WBITS  = 24;      // weight fraction bits
	localparam int WQW    = WBITS + 1;
	localparam int TW     = WQW + NB;  // total weight width
	localparam int PW     = 32 + WQW + 1;  // value times weight
	localparam int SUMW   = PW + NB;   // weighted sum width
	localparam int QW     = 32;        // mean quotient bits
	localparam int WSTEPS = WQW;
	localparam int QSTEPS = QW;
	// s1, s2, s3, weight divide, multiply, sum, prep, mean divide, output
	localparam int LATENCY = 3 + WSTEPS + 3 + QSTEPS + 1;

	localparam int CFG_IW = 2;
	localparam logic [CFG_IW-1:0] REG_SCALE_FACTOR = 2'd0;
	localparam logic [CFG_IW-1:0] REG_VALUE_OFFSET = 2'd1;
	localparam logic [CFG_IW-1:0] REG_MISSING_CODE = 2'd2;

	typedef struct packed {
		logic signed [31:0] sample_a;
		logic signed [31:0] sample_b;
		logic signed [31:0] sample_c;
		logic signed [31:0] sample_d;
		logic [31:0]        dist_a;
		logic [31:0]        dist_b;
		logic [31:0]        dist_c;
		logic [31:0]        dist_d;
		logic               present_a;
		logic               present_b;
		logic               present_c;
		logic               present_d;
	} item_t;

	typedef struct packed {
		logic signed [31:0] interpolated;
		logic               is_missing;
	} result_t;

endpackage

`default_nettype wire

/* rtl/idw_four_point_interpolator.sv */
// ----------------------------------------------------------------------------
// Four-point inverse distance weighting interpolator
// Conditions four neighbour samples and returns their 1/distance weighted mean.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive item and raise start; a word is taken at every rising
//   edge with start high and busy low. busy stays low, so a new grid point can
//   enter in every cycle.
//   Output channel: done is high for one cycle with the result word; the
//   receiver cannot stall, so nothing is held back.
//   Config port: cfg_we, cfg_index, cfg_wdata write scale_factor (0),
//   value_offset (1) and missing_code (2); other indexes are
//   ignored. Write only while the pipeline is empty.
//   Throughput: one word per cycle.
//   The latency is set by the two bit-serial restoring dividers: 25 stages
//   for the weights dmin/dist and 32 stages for the final mean, one
//   quotient bit per stage, plus seven stages of multiply, min and sum.
//   Reset clears all valid bits and loads the register reset values; words
//   in flight are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

`include "idw_four_point_interpolator_defines.svh"

module idw_four_point_interpolator (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	output logic                         busy,
	input  wire idw4_pkg::item_t         item,
	output logic                         done,
	output idw4_pkg::result_t            result,
	input  wire logic                    cfg_we,
	input  wire logic [idw4_pkg::CFG_IW-1:0] cfg_index,
	input  wire logic [31:0]             cfg_wdata
);
	import idw4_pkg::*;

	typedef struct packed {
		logic                  any;
		logic [N-1:0]          use_mask;
		logic [N-1:0][31:0]    val;
		logic [N-1:0][31:0]    span;
		logic [N-1:0][32:0]    rem;
		logic [N-1:0][WQW-1:0] quo;
	} wd_t;

	typedef struct packed {
		logic          any;
		logic          neg;
		logic [TW-1:0] total;
		logic [TW-1:0] rem;
		logic [31:0]   nlo;
		logic [QW-1:0] quo;
	} qd_t;

	logic [31:0] scale_factor_q, value_offset_q, missing_code_q;

	logic                     accept;
	logic [N-1:0][31:0]       raw_in, dist_in;
	logic [N-1:0]             here_in;

	logic                     v_s1;
	logic [N-1:0]             rawmiss_s1;
	logic signed [63:0]       prod_s1 [N];
	logic [N-1:0][31:0]       dist_s1;

	logic                     v_s2;
	logic [N-1:0]             use_s2;
	logic [N-1:0][31:0]       val_s2, dist_s2;
	logic [N-1:0][31:0]       val_c2;
	logic [N-1:0]             use_c2;

	logic                     v_s3;
	wd_t                      wd_c3;
	logic [31:0]              dmin_c;

	logic                     wv_s [0:WSTEPS];
	wd_t                      wd_s [0:WSTEPS];

	logic                     v_m;
	logic                     any_m;
	logic signed [PW-1:0]     prod_m [N];
	logic [TW-1:0]            total_m;

	logic                     v_sm;
	logic                     any_sm;
	logic signed [SUMW-1:0]   sum_sm;
	logic [TW-1:0]            total_sm;

	logic                     v_p;
	logic                     any_p;
	logic                     neg_p;
	logic [SUMW-1:0]          n_p;
	logic [TW-1:0]            total_p;

	logic                     qv_s [0:QSTEPS];
	qd_t                      qd_s [0:QSTEPS];

	logic signed [32:0]       mean_c;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_factor_q <= 32'h0001_0000;
			value_offset_q <= 32'h0000_0000;
			missing_code_q <= 32'h8000_0000;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SCALE_FACTOR: scale_factor_q <= cfg_wdata;
				REG_VALUE_OFFSET: value_offset_q <= cfg_wdata;
				REG_MISSING_CODE: missing_code_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Unpack the input word into lanes
	assign raw_in  = {item.sample_a, item.sample_b, item.sample_c, item.sample_d};
	assign dist_in = {item.dist_a, item.dist_b, item.dist_c, item.dist_d};
	assign here_in = {item.present_a, item.present_b, item.present_c, item.present_d};

	// Stage 1: scale multiply and raw missing test
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else         v_s1 <= accept;
	end
	always_ff @(posedge clk) begin
		for (int i = 0; i < N; i++) begin
			prod_s1[i]    <= $signed(raw_in[i]) * $signed(scale_factor_q);
			rawmiss_s1[i] <= !here_in[i] || (raw_in[i] == missing_code_q);
			dist_s1[i]    <= dist_in[i];
		end
	end

	// Stage 2: round to Q16.16, add offset, saturate, qualify
	always_comb begin
		logic signed [63:0] t;
		logic signed [63:0] s;
		for (int i = 0; i < N; i++) begin
			t = (prod_s1[i] + 64'sd32768) >>> 16;
			s = t + 64'($signed(value_offset_q));
			if (s > 64'sd2147483647)        val_c2[i] = 32'h7FFF_FFFF;
			else if (s < -64'sd2147483648)  val_c2[i] = 32'h8000_0000;
			else                            val_c2[i] = s[31:0];
			use_c2[i] = !rawmiss_s1[i] && (val_c2[i] != missing_code_q)
				&& (dist_s1[i] != 32'd0);
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else         v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		val_s2  <= val_c2;
		use_s2  <= use_c2;
		dist_s2 <= dist_s1;
	end

	// Stage 3: nearest qualifying distance
	always_comb begin
		dmin_c = 32'hFFFF_FFFF;
		for (int i = 0; i < N; i++) begin
			if (use_s2[i] && (dist_s2[i] < dmin_c)) dmin_c = dist_s2[i];
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else         v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		wd_c3.any      <= |use_s2;
		wd_c3.use_mask <= use_s2;
		wd_c3.val      <= val_s2;
		wd_c3.span     <= dist_s2;
		for (int i = 0; i < N; i++) begin
			wd_c3.rem[i] <= {1'b0, dmin_c};
			wd_c3.quo[i] <= '0;
		end
	end

	assign wv_s[0] = v_s3;
	assign wd_s[0] = wd_c3;

	// Weight divider: dmin * 2^24 / dist, one quotient bit per stage
	for (genvar k = 0; k < WSTEPS; k++) begin : g_wdiv
		wd_t nxt;
		always_comb begin
			nxt = wd_s[k];
			for (int i = 0; i < N; i++) begin
				if (wd_s[k].rem[i] >= {1'b0, wd_s[k].span[i]}) begin
					nxt.rem[i] = 33'((wd_s[k].rem[i] - {1'b0, wd_s[k].span[i]}) << 1);
					nxt.quo[i] = {wd_s[k].quo[i][WQW-2:0], 1'b1};
				end else begin
					nxt.rem[i] = 33'(wd_s[k].rem[i] << 1);
					nxt.quo[i] = {wd_s[k].quo[i][WQW-2:0], 1'b0};
				end
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) wv_s[k+1] <= 1'b0;
			else         wv_s[k+1] <= wv_s[k];
		end
		always_ff @(posedge clk) begin
			wd_s[k+1] <= nxt;
		end
	end

	// Multiply stage: value times weight, total weight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_m <= 1'b0;
		else         v_m <= wv_s[WSTEPS];
	end
	always_ff @(posedge clk) begin
		logic [TW-1:0] tot;
		logic [WQW-1:0] w;
		tot = '0;
		for (int i = 0; i < N; i++) begin
			w = wd_s[WSTEPS].use_mask[i] ? wd_s[WSTEPS].quo[i] : '0;
			prod_m[i] <= PW'($signed(wd_s[WSTEPS].val[i]) * $signed({1'b0, w}));
			tot = tot + TW'(w);
		end
		total_m <= tot;
		any_m   <= wd_s[WSTEPS].any;
	end

	// Sum stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_sm <= 1'b0;
		else         v_sm <= v_m;
	end
	always_ff @(posedge clk) begin
		logic signed [SUMW-1:0] acc;
		acc = '0;
		for (int i = 0; i < N; i++) acc = acc + SUMW'(prod_m[i]);
		sum_sm   <= acc;
		total_sm <= total_m;
		any_sm   <= any_m;
	end

	// Prep stage: magnitude plus half the divisor for rounding
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_p <= 1'b0;
		else         v_p <= v_sm;
	end
	always_ff @(posedge clk) begin
		logic [SUMW-1:0] mag;
		mag = sum_sm[SUMW-1] ? SUMW'(-sum_sm) : SUMW'(sum_sm);
		n_p     <= mag + SUMW'(total_sm >> 1);
		neg_p   <= sum_sm[SUMW-1];
		total_p <= total_sm;
		any_p   <= any_sm;
	end

	assign qv_s[0] = v_p;
	always_comb begin
		qd_s[0].any   = any_p;
		qd_s[0].neg   = neg_p;
		qd_s[0].total = total_p;
		qd_s[0].rem   = n_p[QW +: TW];
		qd_s[0].nlo   = n_p[QW-1:0];
		qd_s[0].quo   = '0;
	end

	// Mean divider: one quotient bit per stage
	for (genvar k = 0; k < QSTEPS; k++) begin : g_qdiv
		qd_t nxt;
		logic [TW:0] cand;
		always_comb begin
			nxt  = qd_s[k];
			cand = {qd_s[k].rem, qd_s[k].nlo[31]};
			nxt.nlo = {qd_s[k].nlo[30:0], 1'b0};
			if (cand >= {1'b0, qd_s[k].total}) begin
				nxt.rem = TW'(cand - {1'b0, qd_s[k].total});
				nxt.quo = {qd_s[k].quo[QW-2:0], 1'b1};
			end else begin
				nxt.rem = TW'(cand);
				nxt.quo = {qd_s[k].quo[QW-2:0], 1'b0};
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) qv_s[k+1] <= 1'b0;
			else         qv_s[k+1] <= qv_s[k];
		end
		always_ff @(posedge clk) begin
			qd_s[k+1] <= nxt;
		end
	end

	// Output stage: restore sign, saturate, substitute missing code
	assign mean_c = qd_s[QSTEPS].neg ? -$signed({1'b0, qd_s[QSTEPS].quo})
		: $signed({1'b0, qd_s[QSTEPS].quo});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else         done <= qv_s[QSTEPS];
	end
	always_ff @(posedge clk) begin
		if (!qd_s[QSTEPS].any) begin
			result.interpolated <= missing_code_q;
			result.is_missing   <= 1'b1;
		end else begin
			if (mean_c > 33'sd2147483647) result.interpolated <= 32'h7FFF_FFFF;
			else                          result.interpolated <= mean_c[31:0];
			result.is_missing <= 1'b0;
		end
	end

	`IDW_ASSERT(a_latency, (start && !busy) |-> ##LATENCY done, "accepted word lost")
	`IDW_ASSERT(a_miss_code, (done && result.is_missing) |-> (result.interpolated == missing_code_q), "missing result without missing code")
	`IDW_ASSERT(a_total_nonzero, (v_p && any_p) |-> (total_p != '0), "zero total weight")
	`IDW_ASSERT_NEXT(a_out_follow, qv_s[QSTEPS], done, "divider word not delivered")

endmodule

`default_nettype wire
